>>> rtl/mfbp_pkg.sv
// shared types and constants for the msb-first bit packer
package mfbp_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ALIGN = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [6:0] MAX_WRITE_BITS = 7'd64;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] bit_field;
    logic [6:0]  bit_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [63:0] bits_so_far;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_ALIGN,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] bit_field;
    logic [6:0]  bit_count;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_push_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

endpackage

>>> rtl/msb_first_bit_packer.sv
// top level of the msb-first bit packer
//
// Input requests (in_push / in_full) carry an opcode, a left-aligned 64-bit
// field and a bit count. A write appends the leading bit_count bits, MSB
// first; an align pads the partial byte with zeros and counts the pad bits;
// a flush pads it without counting them. Results (out_empty / out_pop) are
// bytes with the first written bit in bit 7, a flag on the last byte of each
// request and the running bit total after that byte.
// Writes of zero bits or beyond 64 bits, unused opcodes and aligns or flushes
// with no pending bits give no result and leave the state unchanged.
// A request passes the front end into a command queue in the cycle it is
// accepted. The back end takes one command a cycle from it while idle; for
// a command that yields bytes it then emits one byte per cycle into the
// output register while that register is free, and takes no new command
// until its last byte is out, shifting the bytes out of a shift register.
// When the receiver stalls, the output register holds, the back end waits
// and the queue fills until in_full rises. Reset empties the queue and the
// output register and clears the partial byte, fill level and bit total.
module msb_first_bit_packer
  import mfbp_pkg::*;
#(
  parameter int CMD_QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  cmd_push_t q_req;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  cmd_t      q_cmd;

  mfbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_req   (q_req)
  );

  mfbp_cmd_queue #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_req   (q_req),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_cmd   (q_cmd)
  );

  mfbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  assign in_full = q_full;

endmodule

>>> rtl/mfbp_front.sv
// front end: accepts requests, drops no-op ones and masks the unused bits
module mfbp_front
  import mfbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  input  logic      q_full,
  output cmd_push_t q_req
);

  logic [2:0] fill_r;
  logic [2:0] fill_nxt;
  logic       useful;
  logic       accept;
  cmd_kind_t  kind;

  always_comb begin
    useful = 1'b0;
    kind   = CMD_WRITE;
    case (in_item.opcode)
      OP_WRITE: begin
        kind   = CMD_WRITE;
        useful = (in_item.bit_count != 7'd0) && (in_item.bit_count <= MAX_WRITE_BITS);
      end
      OP_ALIGN: begin
        kind   = CMD_ALIGN;
        useful = (fill_r != 3'd0);
      end
      OP_FLUSH: begin
        kind   = CMD_FLUSH;
        useful = (fill_r != 3'd0);
      end
      default: begin
        kind   = CMD_WRITE;
        useful = 1'b0;
      end
    endcase
  end

  assign accept = in_push && !q_full;

  // shadow of the back end's fill level, so empty aligns never reach the queue
  always_comb begin
    fill_nxt = fill_r;
    if (accept && useful) begin
      if (kind == CMD_WRITE) begin
        fill_nxt = fill_r + in_item.bit_count[2:0];
      end else begin
        fill_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 3'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign q_req.push          = accept && useful;
  assign q_req.cmd.kind      = kind;
  assign q_req.cmd.bit_field = in_item.bit_field & ~({64{1'b1}} >> in_item.bit_count);
  assign q_req.cmd.bit_count = in_item.bit_count;

endmodule

>>> rtl/mfbp_cmd_queue.sv
// small command queue between the front and back ends
module mfbp_cmd_queue
  import mfbp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_push_t q_req,
  output logic      q_full,
  input  logic      q_pop,
  output logic      q_empty,
  output cmd_t      q_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_push = q_req.push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_cmd   = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= q_req.cmd;
    end
  end

endmodule

>>> rtl/mfbp_back.sv
// back end: merges commands into the partial byte, one byte per unstalled cycle
module mfbp_back
  import mfbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  back_state_t state_r, state_nxt;
  logic [71:0] sr_r, sr_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [63:0] base_r, base_nxt;
  logic [63:0] total_r, total_nxt;
  logic [7:0]  partial_r, partial_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic        out_v_r, out_v_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic        out_free;
  logic        load;
  logic        emit;
  logic [71:0] stream;
  logic [6:0]  merged_len;
  logic [3:0]  nbytes;

  assign out_free = !out_v_r || out_pop;

  // merged bit stream: held bits on top, new bits right behind them
  assign stream     = {partial_r, 64'd0} | ({q_cmd.bit_field, 8'd0} >> fill_r);
  assign merged_len = {4'd0, fill_r} + q_cmd.bit_count;
  assign nbytes     = merged_len[6:3];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind != CMD_WRITE || nbytes != 4'd0) begin
            state_nxt = BK_EMIT;
          end
        end
      end
      BK_EMIT: begin
        if (out_free && left_r == 4'd1) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    emit = 1'b0;
    case (state_r)
      BK_IDLE: load = !q_empty;
      BK_EMIT: emit = out_free;
      default: begin
        load = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  always_comb begin
    sr_nxt       = sr_r;
    left_nxt     = left_r;
    base_nxt     = base_r;
    total_nxt    = total_r;
    partial_nxt  = partial_r;
    fill_nxt     = fill_r;
    out_v_nxt    = out_v_r && !out_pop;
    out_item_nxt = out_item_r;
    if (load) begin
      case (q_cmd.kind)
        CMD_WRITE: begin
          sr_nxt    = stream;
          left_nxt  = nbytes;
          base_nxt  = total_r - {61'd0, fill_r};
          total_nxt = total_r + {57'd0, q_cmd.bit_count};
          fill_nxt  = merged_len[2:0];
          if (nbytes == 4'd0) begin
            partial_nxt = stream[71:64];
          end
        end
        CMD_ALIGN: begin
          sr_nxt    = {partial_r, 64'd0};
          left_nxt  = 4'd1;
          base_nxt  = total_r - {61'd0, fill_r};
          total_nxt = total_r + {60'd0, 4'd8 - {1'b0, fill_r}};
          fill_nxt  = 3'd0;
        end
        CMD_FLUSH: begin
          sr_nxt   = {partial_r, 64'd0};
          left_nxt = 4'd1;
          // pad bits not counted: the byte reports the unchanged total
          base_nxt = total_r - 64'd8;
          fill_nxt = 3'd0;
        end
        default: begin
          sr_nxt = sr_r;
        end
      endcase
    end
    if (emit) begin
      out_v_nxt                = 1'b1;
      out_item_nxt.out_byte    = sr_r[71:64];
      out_item_nxt.last_of_run = (left_r == 4'd1);
      out_item_nxt.bits_so_far = base_r + 64'd8;
      sr_nxt                   = {sr_r[63:0], 8'd0};
      base_nxt                 = base_r + 64'd8;
      left_nxt                 = left_r - 4'd1;
      if (left_r == 4'd1) begin
        partial_nxt = sr_r[63:56];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      left_r    <= 4'd0;
      total_r   <= 64'd0;
      partial_r <= 8'd0;
      fill_r    <= 3'd0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      left_r    <= left_nxt;
      total_r   <= total_nxt;
      partial_r <= partial_nxt;
      fill_r    <= fill_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r       <= sr_nxt;
    base_r     <= base_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_empty = !out_v_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_emit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> (left_r != 4'd0) && (left_r <= 4'd8))
    else $error("emit count out of range");

  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) |-> ((partial_r & (8'hFF >> fill_r)) == 8'd0))
    else $error("unfilled bits of partial byte not zero");

  a_base_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && left_r != 4'd1) |=> (state_r == BK_EMIT) && (base_r == $past(base_r) + 64'd8))
    else $error("bit total does not advance by a byte between emits");
`endif

endmodule

>>> bench/tb_top.sv
// self-checking testbench for the msb-first bit packer
`timescale 1ns / 100ps

module tb_top;
  import mfbp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_item;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  // packer state as seen by the prediction
  logic [7:0]  pk_partial;
  logic [2:0]  pk_fill;
  logic [63:0] pk_total;

  out_item_t expected_bytes[$];
  int        fail_count = 0;
  int        quiet_cycles = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;
  bit        rx_hold_req = 1'b0;

  msb_first_bit_packer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // work out the bytes one accepted request produces and queue them
  function automatic void pack_request(input in_item_t req);
    logic [7:0] acc;
    int         fill;
    out_item_t  res;
    out_item_t  made[$];
    case (req.opcode)
      OP_WRITE: begin
        if (req.bit_count != 0 && req.bit_count <= MAX_WRITE_BITS) begin
          acc = pk_partial;
          fill = pk_fill;
          for (int i = 0; i < req.bit_count; i++) begin
            acc[7 - fill] = acc[7 - fill] | req.bit_field[63 - i];
            fill++;
            pk_total++;
            if (fill == 8) begin
              res.out_byte = acc;
              res.last_of_run = 1'b0;
              res.bits_so_far = pk_total;
              made.push_back(res);
              acc = '0;
              fill = 0;
            end
          end
          pk_partial = acc;
          pk_fill = fill[2:0];
        end
      end
      OP_ALIGN, OP_FLUSH: begin
        if (pk_fill != 0) begin
          // only an align counts the pad bits
          if (req.opcode == OP_ALIGN) pk_total += 64'(8 - pk_fill);
          res.out_byte = pk_partial;
          res.last_of_run = 1'b0;
          res.bits_so_far = pk_total;
          made.push_back(res);
          pk_partial = '0;
          pk_fill = '0;
        end
      end
      default: ;
    endcase
    if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
    foreach (made[k]) expected_bytes.push_back(made[k]);
  endfunction

  function automatic in_item_t make_req(input logic [1:0] op, input logic [63:0] field,
                                        input logic [6:0] count);
    in_item_t req;
    req.opcode = op;
    req.bit_field = field;
    req.bit_count = count;
    return req;
  endfunction

  function automatic in_item_t rand_request();
    in_item_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    req.bit_field = {$urandom(), $urandom()};
    if (pick < 70) req.opcode = OP_WRITE;
    else if (pick < 82) req.opcode = OP_ALIGN;
    else if (pick < 94) req.opcode = OP_FLUSH;
    else req.opcode = OP_UNUSED;
    pick = $urandom_range(0, 19);
    if (pick == 0) req.bit_count = '0;
    else if (pick == 1) req.bit_count = MAX_WRITE_BITS;
    else if (pick == 2) req.bit_count = 7'($urandom_range(65, 127));
    else if (pick < 9) req.bit_count = 7'($urandom_range(1, 8));
    else req.bit_count = 7'($urandom_range(1, 64));
    return req;
  endfunction

  // one request: optional idle burst, then hold push until accepted
  task automatic send_request(input in_item_t req);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_full);
    pack_request(req);
  endtask

  task automatic run_random(input int useful_target);
    in_item_t req;
    int       useful;
    useful = 0;
    while (useful < useful_target) begin
      req = rand_request();
      if (!(req.opcode == OP_UNUSED ||
            (req.opcode == OP_WRITE &&
             (req.bit_count == 0 || req.bit_count > MAX_WRITE_BITS)) ||
            (req.opcode != OP_WRITE && pk_fill == 0)))
        useful++;
      send_request(req);
    end
  endtask

  task automatic test_directed();
    // nothing pending: the first four give no byte; two full-width writes follow
    send_request(make_req(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0));
    send_request(make_req(OP_ALIGN, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
    send_request(make_req(OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127));
    send_request(make_req(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
    send_request(make_req(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
    send_request(make_req(OP_WRITE, 64'h0000_0000_0000_0000, 7'd64));
    // bits below the count must be dropped
    send_request(make_req(OP_WRITE, 64'hBFFF_FFFF_FFFF_FFFF, 7'd3));
    send_request(make_req(OP_ALIGN, 64'h0, 7'd0));
    send_request(make_req(OP_WRITE, 64'hDFFF_FFFF_FFFF_FFFF, 7'd5));
    send_request(make_req(OP_FLUSH, 64'h0, 7'd0));
    // oversized writes with a partial byte pending
    send_request(make_req(OP_WRITE, 64'h8000_0000_0000_0000, 7'd1));
    send_request(make_req(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd65));
    send_request(make_req(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127));
    send_request(make_req(OP_UNUSED, 64'h0, 7'd0));
    send_request(make_req(OP_WRITE, 64'h5400_0000_0000_0000, 7'd7));
    send_request(make_req(OP_WRITE, 64'hA5C3_0000_0000_0000, 7'd13));
    // misaligned full-width write gives the most bytes
    send_request(make_req(OP_WRITE, 64'h0123_4567_89AB_CDEF, 7'd64));
    send_request(make_req(OP_ALIGN, 64'h0, 7'd0));
    send_request(make_req(OP_WRITE, 64'hE000_0000_0000_0000, 7'd3));
    send_request(make_req(OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
  endtask

  task automatic test_random();
    run_random(60);
  endtask

  // receiver holds off while the sender keeps pushing until in_full rises
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_req = 1'b1;
    repeat (24) send_request(make_req(OP_WRITE, {$urandom(), $urandom()}, MAX_WRITE_BITS));
    send_request(make_req(OP_WRITE, {$urandom(), $urandom()}, 7'd5));
    send_request(make_req(OP_ALIGN, {$urandom(), $urandom()}, 7'($urandom_range(0, 127))));
  endtask

  task automatic test_streaming();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(25);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    pk_partial = '0;
    pk_fill = '0;
    pk_total = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_streaming();
    in_push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("msb_first_bit_packer verification clean");
    end else begin
      $display("msb_first_bit_packer verification failed");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_bytes
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %h total %0d", out_item.out_byte, out_item.bits_so_far);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte expected %h got %h", want.out_byte, out_item.out_byte);
          fail_count++;
        end
        if (out_item.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %b got %b", want.last_of_run, out_item.last_of_run);
          fail_count++;
        end
        if (out_item.bits_so_far !== want.bits_so_far) begin
          $error("bits_so_far expected %0d got %0d", want.bits_so_far, out_item.bits_so_far);
          fail_count++;
        end
      end
    end
  end

  // count cycles with work pending but no handshake on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) ||
        !(in_push || expected_bytes.size() != 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("msb_first_bit_packer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> sim.f
rtl/mfbp_pkg.sv
rtl/mfbp_front.sv
rtl/mfbp_cmd_queue.sv
rtl/mfbp_back.sv
rtl/msb_first_bit_packer.sv
bench/tb_top.sv
